/* sv/asbi_pkg.sv */
`default_nettype none

package asbi_pkg;

    // Entity slot count and bitmap geometry
    localparam int ENTITY_SLOTS = 1024;
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int WORD_COUNT   = (ENTITY_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Fixed field widths
    localparam int ID_W   = 10;
    localparam int CUR_W  = ID_W + 1;
    localparam int SCAN_W = ID_W - BIT_W + 1;

    // Request codes
    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_NEXT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    // Index of the lowest set bit; 63 for an all-zero word
    function automatic logic [BIT_W-1:0] low_bit_index(input t_word v);
        logic [BIT_W-1:0] n;
        n = BIT_W'(WORD_BITS - 1);
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                n = BIT_W'(k);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/asbi_ram.sv */
`default_nettype none

module asbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/active_set_bitmap_iterator.sv */
`default_nettype none

// Active-set bitmap iterator. One activity bit per entity slot is kept in a
// 64-bit-word RAM, plus a running upper bound on the highest active id.
// A set request writes one slot's bit (an active slot raises the bound) and
// restarts the scan pass; a clear request empties the bitmap and zeroes the
// bound (per-word valid flags, no clearing pass). A next request
// returns the lowest active id at or above the scan cursor, or pass_done when
// none is left up to the bound's word, at which point the bound drops to the
// last id found in the pass. Every request gives exactly one response.
// Steps: set passes through S_SET to S_RES; clear and unused codes go
// straight to S_RES. A next request reads at most 16 words, each read in
// S_RD and tested in S_CHK, until it hits or ends the pass in S_RD; each
// word costs one RAM read and one test, and the result goes to S_RES.
// Requests are taken one at a time; a finished response waits in an output
// register so a new request can start while it is still stalled.
module active_set_bitmap_iterator (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [1:0]               i_func,
    input  wire logic [asbi_pkg::ID_W-1:0] i_entity_id,
    input  wire logic                     i_active_flag,
    // response channel
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [asbi_pkg::ID_W-1:0]     o_found_id,
    output logic                          o_found,
    output logic                          o_pass_done,
    output logic [asbi_pkg::ID_W-1:0]     o_highest_bound
);

    localparam int ID_W    = asbi_pkg::ID_W;
    localparam int CUR_W   = asbi_pkg::CUR_W;
    localparam int SCAN_W  = asbi_pkg::SCAN_W;
    localparam int BIT_W   = asbi_pkg::BIT_W;
    localparam int WORD_AW = asbi_pkg::WORD_AW;
    localparam int WORDS   = asbi_pkg::WORD_COUNT;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SET  = 3'd1;   // read data back, write modified word
    localparam logic [2:0] S_RD   = 3'd2;   // issue scan word read or end pass
    localparam logic [2:0] S_CHK  = 3'd3;   // test scan word
    localparam logic [2:0] S_RES  = 3'd4;   // hand response to output register

    logic [2:0]              r_state, n_state;
    logic [ID_W-1:0]         r_bound, n_bound;
    logic [CUR_W-1:0]        r_cursor, n_cursor;
    logic [ID_W-1:0]         r_seen, n_seen;
    logic [SCAN_W-1:0]       r_scan_w, n_scan_w;
    logic                    r_first, n_first;
    logic [WORDS-1:0]        r_wvalid, n_wvalid;
    logic                    r_rd_valid;
    logic [ID_W-1:0]         r_id;
    logic                    r_flag;

    // pending response
    logic [ID_W-1:0]         r_res_id, n_res_id;
    logic                    r_res_found, n_res_found;
    logic                    r_res_done, n_res_done;

    // output register
    logic                    r_out_valid;
    logic [ID_W-1:0]         r_out_id;
    logic                    r_out_found;
    logic                    r_out_done;
    logic [ID_W-1:0]         r_out_bound;

    // RAM port signals
    logic                    ram_we;
    logic [WORD_AW-1:0]      ram_waddr;
    logic [WORD_AW-1:0]      ram_raddr;
    asbi_pkg::t_word         ram_wdata;
    asbi_pkg::t_word         ram_rdata;

    logic                    req_accept;
    logic                    res_load;
    logic [31:0]             set_word_ext;
    logic [31:0]             scan_word_ext;
    logic [31:0]             lim_ext;
    logic [SCAN_W-1:0]       scan_lim;
    asbi_pkg::t_word         cur_word;
    asbi_pkg::t_word         scan_bits;
    logic [BIT_W-1:0]        hit_bit;
    logic [ID_W-1:0]         hit_id;

    assign req_accept  = i_valid && !o_stall;
    assign res_load    = (r_state == S_RES) && (!r_out_valid || !i_stall);

    // word addresses, widened then cut to the RAM address width
    assign set_word_ext  = 32'(r_id[ID_W-1:BIT_W]);
    assign scan_word_ext = 32'(r_scan_w);

    // scan limit: bound's word + 1, capped at the word count
    assign lim_ext  = 32'(r_bound[ID_W-1:BIT_W]) + 32'd1;
    assign scan_lim = (lim_ext > WORDS) ? SCAN_W'(WORDS) : lim_ext[SCAN_W-1:0];

    // word read last cycle; never-written words read as zero
    assign cur_word  = r_rd_valid ? ram_rdata : '0;
    assign scan_bits = r_first ? (cur_word & ({asbi_pkg::WORD_BITS{1'b1}} << r_cursor[BIT_W-1:0]))
                               : cur_word;
    assign hit_bit   = asbi_pkg::low_bit_index(scan_bits);
    assign hit_id    = {r_scan_w[SCAN_W-2:0], hit_bit};

    // scan reads while scanning, otherwise the word of the offered id
    always_comb begin
        ram_raddr = (r_state == S_RD) ? scan_word_ext[WORD_AW-1:0]
                                      : WORD_AW'(i_entity_id[ID_W-1:BIT_W]);
    end

    assign ram_waddr = set_word_ext[WORD_AW-1:0];
    assign ram_we    = (r_state == S_SET);
    assign ram_wdata = r_flag ? (cur_word | (asbi_pkg::t_word'(1) << r_id[BIT_W-1:0]))
                              : (cur_word & ~(asbi_pkg::t_word'(1) << r_id[BIT_W-1:0]));

    always_comb begin
        n_state     = r_state;
        n_bound     = r_bound;
        n_cursor    = r_cursor;
        n_seen      = r_seen;
        n_scan_w    = r_scan_w;
        n_first     = r_first;
        n_wvalid    = r_wvalid;
        n_res_id    = r_res_id;
        n_res_found = r_res_found;
        n_res_done  = r_res_done;
        case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_res_id    = '0;
                    n_res_found = 1'b0;
                    n_res_done  = 1'b0;
                    case (i_func)
                        asbi_pkg::FUNC_SET: begin
                            // out-of-range ids answer without touching state
                            n_state = (32'(i_entity_id) < asbi_pkg::ENTITY_SLOTS) ? S_SET
                                                                                  : S_RES;
                        end
                        asbi_pkg::FUNC_NEXT: begin
                            n_scan_w = r_cursor[CUR_W-1:BIT_W];
                            n_first  = 1'b1;
                            n_state  = S_RD;
                        end
                        asbi_pkg::FUNC_CLEAR: begin
                            n_wvalid = '0;
                            n_bound  = '0;
                            n_cursor = '0;
                            n_seen   = '0;
                            n_state  = S_RES;
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_SET: begin
                n_wvalid[ram_waddr] = 1'b1;
                if (r_flag && (r_id > r_bound)) begin
                    n_bound = r_id;
                end
                n_cursor = '0;
                n_seen   = '0;
                n_state  = S_RES;
            end
            S_RD: begin
                if (r_scan_w >= scan_lim) begin
                    // pass over: bound falls to last id found
                    n_res_done = 1'b1;
                    n_bound    = r_seen;
                    n_cursor   = '0;
                    n_seen     = '0;
                    n_state    = S_RES;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (scan_bits != '0) begin
                    n_res_id    = hit_id;
                    n_res_found = 1'b1;
                    n_cursor    = CUR_W'(hit_id) + CUR_W'(1);
                    n_seen      = hit_id;
                    n_state     = S_RES;
                end else begin
                    n_scan_w = r_scan_w + SCAN_W'(1);
                    n_first  = 1'b0;
                    n_state  = S_RD;
                end
            end
            S_RES: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bound     <= '0;
            r_cursor    <= '0;
            r_seen      <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bound  <= n_bound;
            r_cursor <= n_cursor;
            r_seen   <= n_seen;
            r_wvalid <= n_wvalid;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_w    <= n_scan_w;
        r_first     <= n_first;
        r_res_id    <= n_res_id;
        r_res_found <= n_res_found;
        r_res_done  <= n_res_done;
        r_rd_valid  <= r_wvalid[ram_raddr];
        if (req_accept) begin
            r_id   <= i_entity_id;
            r_flag <= i_active_flag;
        end
        if (res_load) begin
            r_out_id    <= r_res_id;
            r_out_found <= r_res_found;
            r_out_done  <= r_res_done;
            r_out_bound <= r_bound;
        end
    end

    asbi_ram #(
        .WIDTH(asbi_pkg::WORD_BITS),
        .DEPTH(WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_found_id      = r_out_id;
    assign o_found         = r_out_found;
    assign o_pass_done     = r_out_done;
    assign o_highest_bound = r_out_bound;

endmodule

`default_nettype wire
